// ----- design/oal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list package
// Transaction types, operation and status codes, and the control interface
// between the list controller and its datapath.
// ----------------------------------------------------------------------------
package oal_pkg;

  // Field widths of one transaction.
  localparam int OP_W   = 3;
  localparam int POS_W  = 8;
  localparam int DATA_W = 32;
  localparam int STS_W  = 2;
  localparam int LEN_W  = 8;

  // Request operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_FRONT  = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4,
    OP_WRITE  = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    ST_OK   = 2'd0,
    ST_POS  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MOVE,
    S_COMMIT,
    S_RESULT
  } state_t;

  // Input transaction.
  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } oal_in_t;

  // Result transaction.
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [STS_W-1:0]         status;
    logic [LEN_W-1:0]         length;
    logic                     empty_flag;
    logic                     full_flag;
  } oal_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic setup;
    logic step;
    logic commit;
    logic publish;
  } oal_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic move_done;
    logic out_free;
  } oal_sts_t;

endpackage

// ----- design/oal_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list controller
// Sequences one request through check, entry move, commit and result.
// ----------------------------------------------------------------------------
module oal_ctrl
  import oal_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  oal_sts_t sts,
  output oal_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        cmd.step = 1'b1;
        if (sts.move_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/oal_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list datapath
// Holds the entry memory, the entry count, the move sweep and the result
// register.
// ----------------------------------------------------------------------------
module oal_dpath
  import oal_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  oal_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output oal_out_t out_data,
  input  oal_cmd_t cmd,
  output oal_sts_t sts
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Entry storage.
  logic [DATA_W-1:0] mem_r [CAPACITY];
  logic [DATA_W-1:0] rdata_r;

  // Request and bookkeeping registers.
  op_t               op_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic [CNT_W-1:0]  count_r;
  status_t           status_r;
  logic [AW-1:0]     ptr_r;
  logic [CNT_W-1:0]  n_r;
  logic              up_r;
  logic              cap_op_r;
  logic              mov_wr_r;
  logic              first_r;
  logic [AW-1:0]     at_r;
  logic              fin_wr_r;
  logic              mv_r;
  logic              mv_cap_r;
  logic              mv_wr_r;
  logic [AW-1:0]     mv_dst_r;
  logic [DATA_W-1:0] rd_r;
  logic              out_valid_r;
  oal_out_t          out_data_r;

  // Plan computed from the captured request.
  status_t          st_plan;
  logic [CNT_W-1:0] n_plan;
  logic [AW-1:0]    ptr_plan;
  logic [AW-1:0]    at_plan;
  logic             up_plan;
  logic             cap_plan;
  logic             mwr_plan;
  logic             fwr_plan;

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             list_full;
  logic             list_empty;
  logic             issue;
  logic             first_cap;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic [CNT_W-1:0]  count_nxt;

  assign pos_x      = CMP_W'(pos_r);
  assign cnt_x      = CMP_W'(count_r);
  assign list_full  = (count_r == CNT_W'(CAPACITY));
  assign list_empty = (count_r == '0);
  assign issue      = cmd.step && (n_r != '0);
  assign first_cap  = cap_op_r && first_r;

  // Range checks and the move plan for the request.
  always_comb begin
    st_plan  = ST_OK;
    n_plan   = '0;
    ptr_plan = '0;
    at_plan  = '0;
    up_plan  = 1'b0;
    cap_plan = 1'b0;
    mwr_plan = 1'b0;
    fwr_plan = 1'b0;
    unique case (op_r)
      OP_INSERT: begin
        if (list_full) begin
          st_plan = ST_FULL;
        end else if (pos_x > cnt_x) begin
          st_plan = ST_POS;
        end else begin
          at_plan  = AW'(pos_x);
          n_plan   = CNT_W'(cnt_x - pos_x);
          ptr_plan = AW'(cnt_x - CMP_W'(1));
          mwr_plan = 1'b1;
          fwr_plan = 1'b1;
        end
      end
      OP_APPEND: begin
        if (list_full) begin
          st_plan = ST_FULL;
        end else begin
          at_plan  = AW'(cnt_x);
          fwr_plan = 1'b1;
        end
      end
      OP_FRONT: begin
        if (list_full) begin
          st_plan = ST_FULL;
        end else begin
          n_plan   = count_r;
          ptr_plan = AW'(cnt_x - CMP_W'(1));
          mwr_plan = 1'b1;
          fwr_plan = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos_x >= cnt_x) begin
          st_plan = ST_POS;
        end else begin
          n_plan   = CNT_W'(cnt_x - pos_x);
          ptr_plan = AW'(pos_x);
          up_plan  = 1'b1;
          cap_plan = 1'b1;
          mwr_plan = 1'b1;
        end
      end
      OP_READ: begin
        if (pos_x >= cnt_x) begin
          st_plan = ST_POS;
        end else begin
          n_plan   = CNT_W'(1);
          ptr_plan = AW'(pos_x);
          cap_plan = 1'b1;
        end
      end
      OP_WRITE: begin
        if (pos_x >= CMP_W'(CAPACITY)) begin
          st_plan = ST_POS;
        end else begin
          at_plan  = AW'(pos_x);
          fwr_plan = 1'b1;
        end
      end
      default: begin
        st_plan = ST_OK;
      end
    endcase
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= op_t'(in_data.opcode);
      pos_r <= in_data.position;
      val_r <= in_data.value;
    end
  end

  // Plan registers, loaded once per request.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      status_r <= st_plan;
      at_r     <= at_plan;
      up_r     <= up_plan;
      cap_op_r <= cap_plan;
      mov_wr_r <= mwr_plan;
      fin_wr_r <= fwr_plan;
    end
  end

  // Move sweep: one memory read issued per cycle, stepping the pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r     <= '0;
      first_r <= 1'b0;
      mv_r    <= 1'b0;
    end else if (cmd.setup) begin
      n_r     <= n_plan;
      first_r <= 1'b1;
      mv_r    <= 1'b0;
    end else if (issue) begin
      n_r     <= n_r - CNT_W'(1);
      first_r <= 1'b0;
      mv_r    <= 1'b1;
    end else begin
      mv_r    <= 1'b0;
    end
  end

  // Pointer and the write-back stage that follows each read.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      ptr_r <= ptr_plan;
    end else if (issue) begin
      ptr_r    <= up_r ? ptr_r + AW'(1) : ptr_r - AW'(1);
      mv_dst_r <= up_r ? ptr_r - AW'(1) : ptr_r + AW'(1);
      mv_cap_r <= first_cap;
      mv_wr_r  <= mov_wr_r && !first_cap;
    end
  end

  // Removed or read entry; zero for every other operation.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rd_r <= '0;
    end else if (mv_r && mv_cap_r) begin
      rd_r <= rdata_r;
    end
  end

  // Memory write select: moved entry first, new value at commit.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = mv_dst_r;
    wr_data = rdata_r;
    if (mv_r && mv_wr_r) begin
      wr_en = 1'b1;
    end else if (cmd.commit && fin_wr_r) begin
      wr_en   = 1'b1;
      wr_addr = at_r;
      wr_data = val_r;
    end
  end

  // Entry memory with registered read.
  always_ff @(posedge clk) begin
    if (issue) begin
      rdata_r <= mem_r[ptr_r];
    end
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Count update at commit.
  always_comb begin
    count_nxt = count_r;
    if (status_r == ST_OK) begin
      unique case (op_r)
        OP_INSERT, OP_APPEND, OP_FRONT: count_nxt = count_r + CNT_W'(1);
        OP_DELETE:                      count_nxt = count_r - CNT_W'(1);
        OP_CLEAR:                       count_nxt = '0;
        default:                        count_nxt = count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // Result register; a waiting result does not block the next request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data_r.read_value <= rd_r;
      out_data_r.status     <= status_r;
      out_data_r.length     <= cnt_x[LEN_W-1:0];
      out_data_r.empty_flag <= list_empty;
      out_data_r.full_flag  <= list_full;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign sts.move_done = (n_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

// ----- design/ordered_array_list_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list unit
// Ordered list of signed 32-bit entries with positional insert, append,
// insert at front, delete, read, overwrite and clear.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives one result. A request
// passes through setup, the memory sweep and commit, and its result is
// presented before the next request can be accepted. The memory sweep reads
// count - position entries for insert and delete, count for insert at
// front, 1 for read, and none for every other request and for any request
// rejected with an error status. The sweep moves one entry per cycle through
// the single read port and single write port of the entry memory. A new
// result waits while the previous one is still held off by the receiver,
// which adds the cycles of that stall. Errors (bad position, full list) are
// reported in status and leave the list unchanged. The result sits in an
// output register, so the next request is accepted while it waits. The entry
// memory needs no clearing after reset.
module ordered_array_list_unit
  import oal_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  oal_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output oal_out_t out_data
);

  oal_cmd_t cmd;
  oal_sts_t sts;

  // Request sequencer.
  oal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Entry storage and result path.
  oal_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- tb/ordered_array_list_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered array list unit testbench
// Drives list requests through the valid/stall input channel and checks each
// result transaction against a list model kept in a small scoreboard. A short
// directed sequence covers empty, out-of-range and boundary cases. Random
// phases then fill the list to capacity, drain it and churn it, with idle
// bursts on both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module ordered_array_list_unit_tb
  import oal_pkg::*;
();

  localparam int LIST_CAP        = 128;
  localparam int RANDOM_ITEMS    = 1780;
  localparam int CALM_ITEMS      = 150;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 2 * (LIST_CAP + 10);
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int MAX_PRINTED     = 40;

  // Opcode 7 is not an operation; the block must answer it with no change.
  localparam logic [OP_W-1:0] OP_NOP = 3'd7;

  // Request mixes used by the random part.
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_CHURN} mix_t;

  // List model and queue of expected results.
  class list_scoreboard;
    logic [DATA_W-1:0] slots [LIST_CAP];
    int unsigned       held;
    oal_out_t          expected_q[$];
    int unsigned       errors;
    int unsigned       serial;

    function new();
      held   = 0;
      errors = 0;
      serial = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
    endtask

    // Opens a slot at the given index, moving later entries up by one.
    function void open_slot(int unsigned at, logic [DATA_W-1:0] v);
      for (int unsigned i = held; i > at; i--) slots[i] = slots[i - 1];
      slots[at] = v;
      held++;
    endfunction

    // Applies an accepted request to the list and queues its result.
    function void note_request(oal_in_t req);
      oal_out_t    res;
      int unsigned pos;
      pos    = req.position;
      res    = '0;
      res.status = ST_OK;
      case (req.opcode)
        OP_INSERT: begin
          if (held >= LIST_CAP) res.status = ST_FULL;
          else if (pos > held) res.status = ST_POS;
          else open_slot(pos, req.value);
        end
        OP_APPEND: begin
          if (held >= LIST_CAP) res.status = ST_FULL;
          else open_slot(held, req.value);
        end
        OP_FRONT: begin
          if (held >= LIST_CAP) res.status = ST_FULL;
          else open_slot(0, req.value);
        end
        OP_DELETE: begin
          if (pos >= held) begin
            res.status = ST_POS;
          end else begin
            res.read_value = slots[pos];
            for (int unsigned i = pos; i + 1 < held; i++) slots[i] = slots[i + 1];
            held--;
          end
        end
        OP_READ: begin
          if (pos >= held) res.status = ST_POS;
          else res.read_value = slots[pos];
        end
        OP_WRITE: begin
          if (pos >= LIST_CAP) res.status = ST_POS;
          else slots[pos] = req.value;
        end
        OP_CLEAR: held = 0;
        default: ;
      endcase
      res.length     = LEN_W'(held);
      res.empty_flag = (held == 0);
      res.full_flag  = (held == LIST_CAP);
      expected_q.push_back(res);
    endfunction

    task cmp_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got 0x%0h expected 0x%0h", serial, name, got, want));
    endtask

    // Compares one result transaction with the oldest expectation.
    task check_result(oal_out_t got);
      oal_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", serial));
      end else begin
        want = expected_q.pop_front();
        cmp_field("read_value", got.read_value, want.read_value);
        cmp_field("status", DATA_W'(got.status), DATA_W'(want.status));
        cmp_field("length", DATA_W'(got.length), DATA_W'(want.length));
        cmp_field("empty_flag", DATA_W'(got.empty_flag), DATA_W'(want.empty_flag));
        cmp_field("full_flag", DATA_W'(got.full_flag), DATA_W'(want.full_flag));
      end
      serial++;
    endtask
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  oal_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  oal_out_t out_data;

  list_scoreboard sb = new();
  bit calm_tail = 1'b0;

  ordered_array_list_unit #(
    .CAPACITY (LIST_CAP)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic oal_in_t mk(logic [OP_W-1:0] op, int pos, logic [DATA_W-1:0] v);
    oal_in_t req;
    req.opcode   = op;
    req.position = POS_W'(pos);
    req.value    = v;
    return req;
  endfunction

  // Presents one request and holds it until the block takes it.
  task automatic offer(input oal_in_t req);
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_request(req);
  endtask

  // Drops valid for a short random burst now and then.
  task automatic maybe_idle();
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Picks an operation by weight for the current mix.
  function automatic logic [OP_W-1:0] pick_op(mix_t mix);
    int w [8];
    int roll;
    case (mix)
      MIX_FILL:  w = '{30, 25, 15, 10, 8, 8, 0, 4};
      MIX_DRAIN: w = '{5, 5, 5, 60, 10, 10, 2, 3};
      default:   w = '{15, 10, 10, 25, 15, 15, 5, 5};
    endcase
    roll = $urandom_range(0, 99);
    for (int i = 0; i < 8; i++) begin
      if (roll < w[i]) return OP_W'(i);
      roll -= w[i];
    end
    return OP_NOP;
  endfunction

  // Builds a random request; most positions are legal for the current length.
  function automatic oal_in_t random_request(mix_t mix, int unsigned cnt);
    logic [OP_W-1:0] op;
    int              pos;
    op = pick_op(mix);
    if ($urandom_range(0, 7) == 0) begin
      pos = $urandom_range(0, 255);
    end else begin
      case (op)
        OP_INSERT:          pos = $urandom_range(0, cnt);
        OP_DELETE, OP_READ: pos = (cnt > 0) ? $urandom_range(0, cnt - 1) : 0;
        OP_WRITE:           pos = $urandom_range(0, LIST_CAP - 1);
        default:            pos = $urandom_range(0, 255);
      endcase
    end
    return mk(op, pos, pick_value());
  endfunction

  // Result side: random stall bursts, one long hold-off, and checking.
  initial begin : result_sink
    int stall_left;
    int taken;
    bit held_off;
    stall_left = 0;
    taken      = 0;
    held_off   = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_data);
        taken++;
      end
      if (!held_off && taken == 150) begin
        held_off   = 1'b1;
        stall_left = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && !calm_tail && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 5);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  // Stimulus and end of run.
  initial begin : stimulus
    mix_t mix;
    int   phase_ops;
    int   at_edge;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, boundaries of position and value, every opcode.
    offer(mk(OP_READ, 0, '0));
    offer(mk(OP_DELETE, 0, '0));
    offer(mk(OP_INSERT, 1, 32'h1234_5678));
    offer(mk(OP_INSERT, 0, 32'h7FFF_FFFF));
    offer(mk(OP_APPEND, 0, 32'h8000_0000));
    offer(mk(OP_FRONT, 255, 32'h0000_0000));
    offer(mk(OP_INSERT, 3, 32'hFFFF_FFFF));
    offer(mk(OP_INSERT, 1, 32'h5555_AAAA));
    offer(mk(OP_READ, 4, '0));
    offer(mk(OP_READ, 5, '0));
    offer(mk(OP_WRITE, 2, 32'hA5A5_5A5A));
    // Overwrite past the length but inside capacity leaves the length alone.
    offer(mk(OP_WRITE, LIST_CAP - 1, 32'h0F0F_F0F0));
    offer(mk(OP_WRITE, LIST_CAP, 32'h1111_1111));
    offer(mk(OP_WRITE, 255, 32'h2222_2222));
    offer(mk(OP_DELETE, 255, '0));
    offer(mk(OP_NOP, 255, 32'hFFFF_FFFF));
    offer(mk(OP_DELETE, 0, '0));
    offer(mk(OP_DELETE, 3, '0));
    offer(mk(OP_READ, 0, '0));
    offer(mk(OP_CLEAR, 0, '0));
    offer(mk(OP_READ, 0, '0));
    offer(mk(OP_APPEND, 0, 32'h0000_0001));

    // Random: fill to capacity, drain to empty, churn, and repeat.
    mix       = MIX_FILL;
    phase_ops = 0;
    at_edge   = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm_tail = (n >= RANDOM_ITEMS - CALM_ITEMS);
      phase_ops++;
      case (mix)
        MIX_FILL: begin
          if (sb.held == LIST_CAP) at_edge++;
          if (at_edge > 10 || phase_ops > 600) begin
            mix = MIX_DRAIN;
            phase_ops = 0;
            at_edge = 0;
          end
        end
        MIX_DRAIN: begin
          if (sb.held == 0) at_edge++;
          if (at_edge > 5 || phase_ops > 600) begin
            mix = MIX_CHURN;
            phase_ops = 0;
            at_edge = 0;
          end
        end
        default: begin
          if (phase_ops > 120) begin
            mix = MIX_FILL;
            phase_ops = 0;
          end
        end
      endcase
      maybe_idle();
      offer(random_request(mix, sb.held));
    end
    in_valid <= 1'b0;

    // Wait for every result, then give the block time to misbehave.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
